/* design/smf_pkg.sv */
// Shared constants and types for the sliding median filter.
// No dependencies; compiled before every other file of the block.
package smf_pkg;

    localparam int WINDOW_MAX  = 16;
    localparam int SAMPLE_BITS = 24;
    localparam int IDX_BITS    = $clog2(WINDOW_MAX);
    localparam int LEN_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int CFG_BITS    = 5;

    localparam logic [CFG_BITS-1:0] WINDOW_LEN_RESET = CFG_BITS'(5);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [IDX_BITS-1:0]           idx_t;
    typedef logic [LEN_BITS-1:0]           len_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic shift;    // new transaction: samples move one cell on
        logic step;     // ranking cycle: probes move one cell round the ring
        len_t len;      // effective window length
    } ctrl_t;

endpackage

/* design/smf_sample_if.sv */
// Input channel of the sliding median filter: sample and record-start flag.
// Depends on smf_pkg.
interface smf_sample_if;
    logic             valid;
    logic             ready;
    smf_pkg::sample_t sample;
    logic             start_record;

    modport source (output valid, output sample, output start_record, input ready);
    modport sink   (input valid, input sample, input start_record, output ready);
endinterface

/* design/smf_median_if.sv */
// Output channel of the sliding median filter: one median per transaction once the window has filled.
// Depends on smf_pkg.
interface smf_median_if;
    logic             valid;
    logic             ready;
    smf_pkg::sample_t median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

/* design/smf_cell.sv */
// One cell of the median chain: holds one sample of the window (newest at
// cell 0) and ranks it against probes circulating round the ring. Uses smf_pkg.
module smf_cell (
    input  logic             clk,
    input  smf_pkg::ctrl_t   ctrl,
    input  smf_pkg::idx_t    idx,
    input  smf_pkg::sample_t shift_in,
    input  smf_pkg::sample_t probe_in,
    input  smf_pkg::idx_t    probe_age_in,
    output smf_pkg::sample_t sample,
    output smf_pkg::sample_t probe,
    output smf_pkg::idx_t    probe_age,
    output smf_pkg::idx_t    rank
);

    smf_pkg::sample_t sample_reg;
    smf_pkg::sample_t probe_reg;
    smf_pkg::idx_t    age_reg;
    smf_pkg::idx_t    rank_reg;
    logic             age_in_window;
    logic             hit;

    // Probe counts below us if it lies in the window and is smaller, ties
    // broken by age so every rank is unique.
    assign age_in_window = smf_pkg::len_t'(age_reg) < ctrl.len;
    assign hit = age_in_window &&
                 ((probe_reg < sample_reg) ||
                  ((probe_reg == sample_reg) && (age_reg < idx)));

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            sample_reg <= shift_in;
            probe_reg  <= shift_in;
            age_reg    <= idx;
            rank_reg   <= '0;
        end
        else if (ctrl.step)
        begin
            probe_reg <= probe_in;
            age_reg   <= probe_age_in;
            rank_reg  <= rank_reg + smf_pkg::idx_t'(hit);
        end
    end

    assign sample    = sample_reg;
    assign probe     = probe_reg;
    assign probe_age = age_reg;
    assign rank      = rank_reg;

endmodule

/* design/sliding_median_filter.sv */
// Sliding-window median filter. Each transaction shifts its sample into a
// chain of WINDOW_MAX cells; once the record holds window_len samples, a copy
// of every sample circulates past every cell of the ring so each
// cell counts how many window samples lie below its own, and the cell whose
// rank is window_len/2 (upper median for even lengths) supplies the result.
// An item that yields a median holds off the next until the median enters
// the output register, which may wait on medians.ready; one that yields none
// (window still filling) leaves the filter idle. window_len 0 acts as 1, above
// WINDOW_MAX as WINDOW_MAX; start_record restarts the fill before its sample.
module sliding_median_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    smf_sample_if.sink                     samples,
    smf_median_if.source                   medians,
    input  logic                           cfg_wr_en,
    input  logic [smf_pkg::CFG_BITS-1:0]   cfg_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RANK,
        ST_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [smf_pkg::CFG_BITS-1:0]  window_len_reg;
    smf_pkg::len_t                 fill_count_reg, fill_count_next;
    smf_pkg::idx_t                 step_cnt_reg, step_cnt_next;
    logic                          out_valid_reg, out_valid_next;
    smf_pkg::sample_t              median_reg, median_next;

    smf_pkg::ctrl_t                ctrl;
    smf_pkg::len_t                 eff_len;
    logic                          accept;
    logic                          emit;

    smf_pkg::sample_t              cell_sample [smf_pkg::WINDOW_MAX];
    smf_pkg::sample_t              cell_probe  [smf_pkg::WINDOW_MAX];
    smf_pkg::idx_t                 cell_age    [smf_pkg::WINDOW_MAX];
    smf_pkg::idx_t                 cell_rank   [smf_pkg::WINDOW_MAX];
    smf_pkg::sample_t              selected;

    always_comb
    begin
        if (window_len_reg == '0)
            eff_len = smf_pkg::len_t'(1);
        else if (int'(window_len_reg) > smf_pkg::WINDOW_MAX)
            eff_len = smf_pkg::len_t'(smf_pkg::WINDOW_MAX);
        else
            eff_len = smf_pkg::len_t'(window_len_reg);
    end

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign emit          = (state_reg == ST_EMIT) && (!out_valid_reg || medians.ready);

    assign ctrl.shift = accept;
    assign ctrl.step  = (state_reg == ST_RANK);
    assign ctrl.len   = eff_len;

    for (genvar i = 0; i < smf_pkg::WINDOW_MAX; i++)
    begin : g_cell
        localparam int PREV = (i + smf_pkg::WINDOW_MAX - 1) % smf_pkg::WINDOW_MAX;
        smf_pkg::sample_t shift_src;

        if (i == 0)
        begin : g_head
            assign shift_src = samples.sample;
        end
        else
        begin : g_body
            assign shift_src = cell_sample[i-1];
        end

        smf_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .idx          (smf_pkg::idx_t'(i)),
            .shift_in     (shift_src),
            .probe_in     (cell_probe[PREV]),
            .probe_age_in (cell_age[PREV]),
            .sample       (cell_sample[i]),
            .probe        (cell_probe[i]),
            .probe_age    (cell_age[i]),
            .rank         (cell_rank[i])
        );
    end

    // Exactly one window cell holds rank len/2
    always_comb
    begin
        selected = '0;
        for (int i = 0; i < smf_pkg::WINDOW_MAX; i++)
        begin
            if ((smf_pkg::len_t'(i) < eff_len) &&
                (smf_pkg::len_t'(cell_rank[i]) == (eff_len >> 1)))
                selected = selected | cell_sample[i];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        step_cnt_next   = step_cnt_reg;
        out_valid_next  = out_valid_reg;
        median_next     = median_reg;

        if (out_valid_reg && medians.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (samples.start_record)
                        fill_count_next = smf_pkg::len_t'(1);
                    else if (fill_count_reg < smf_pkg::len_t'(smf_pkg::WINDOW_MAX))
                        fill_count_next = fill_count_reg + smf_pkg::len_t'(1);
                    step_cnt_next = '0;
                    if (fill_count_next >= eff_len)
                        state_next = ST_RANK;
                end
            end
            ST_RANK:
            begin
                step_cnt_next = step_cnt_reg + smf_pkg::idx_t'(1);
                if (step_cnt_reg == smf_pkg::idx_t'(smf_pkg::WINDOW_MAX - 1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    median_next    = selected;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_len_reg <= smf_pkg::WINDOW_LEN_RESET;
            fill_count_reg <= '0;
            step_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            step_cnt_reg   <= step_cnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
                window_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
    end

    assign medians.valid  = out_valid_reg;
    assign medians.median = median_reg;

endmodule
